/* hw/rtl/drvm_pkg.sv */
// Shared types, codes and helpers for the robot drive mode controller.
// No dependencies; every other file of the block refers to this package.
package drvm_pkg;

   // Width of the turn countdown.
   localparam int TICK_COUNT_BITS = 8;
   localparam logic [TICK_COUNT_BITS-1:0] TURN_MAX = '1;

   // Field widths of the channels.
   localparam int CHAR_BITS = 8;
   localparam int CFG_DATA_BITS = 8;
   localparam int CSR_INDEX_BITS = 1;

   // Configuration register indexes.
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MANUAL_TURN = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FOLLOW_TURN = 1'd1;

   // Reset values of the configuration registers.
   localparam logic [CFG_DATA_BITS-1:0] MANUAL_TURN_RESET = 8'd149;
   localparam logic [CFG_DATA_BITS-1:0] FOLLOW_TURN_RESET = 8'd49;

   // Item kinds.
   localparam logic ACTION_CHAR = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Operating modes.
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_MANUAL = 2'd1;
   localparam logic [1:0] MODE_WAIT   = 2'd2;
   localparam logic [1:0] MODE_FOLLOW = 2'd3;

   // Motor patterns: bit 3 left_fwd, bit 2 left_rev, bit 1 right_fwd, bit 0 right_rev.
   localparam logic [3:0] PAT_OFF   = 4'h0;
   localparam logic [3:0] PAT_FWD   = 4'hA;
   localparam logic [3:0] PAT_BACK  = 4'h5;
   localparam logic [3:0] PAT_RIGHT = 4'h6;
   localparam logic [3:0] PAT_LEFT  = 4'h9;

   // Command characters.
   localparam logic [CHAR_BITS-1:0] CHAR_MANUAL = 8'h31;  // '1'
   localparam logic [CHAR_BITS-1:0] CHAR_LINE   = 8'h32;  // '2'
   localparam logic [CHAR_BITS-1:0] CHAR_GO     = 8'h67;  // 'g'
   localparam logic [CHAR_BITS-1:0] CHAR_QUIT   = 8'h71;  // 'q'
   localparam logic [CHAR_BITS-1:0] CHAR_FWD    = 8'h77;  // 'w'
   localparam logic [CHAR_BITS-1:0] CHAR_BACK   = 8'h73;  // 's'
   localparam logic [CHAR_BITS-1:0] CHAR_LEFT   = 8'h61;  // 'a'
   localparam logic [CHAR_BITS-1:0] CHAR_RIGHT  = 8'h64;  // 'd'
   localparam logic [CHAR_BITS-1:0] CHAR_STOP   = 8'h70;  // 'p'

   // One input beat.
   typedef struct packed {
      logic                 action;
      logic [CHAR_BITS-1:0] char_code;
      logic                 right_sensor;
      logic                 left_sensor;
   } item_type;

   // Controller state.
   typedef struct packed {
      logic [1:0]                 mode;
      logic [3:0]                 motor;
      logic [TICK_COUNT_BITS-1:0] turn_remaining;
      logic                       turn_then_forward;
      logic                       quit_pending;
   } state_type;

   // One result beat.
   typedef struct packed {
      logic       left_fwd;
      logic       left_rev;
      logic       right_fwd;
      logic       right_rev;
      logic [1:0] mode;
      logic       turning;
      logic       dropped;
   } result_type;

   // Saturate a configured turn length to the counter range.
   function automatic logic [TICK_COUNT_BITS-1:0] clamp_turn(
      input logic [CFG_DATA_BITS-1:0] ticks
   );
      logic [CFG_DATA_BITS+TICK_COUNT_BITS:0] wide;
      logic [CFG_DATA_BITS+TICK_COUNT_BITS:0] limit;
      wide  = (CFG_DATA_BITS+TICK_COUNT_BITS+1)'(ticks);
      limit = (CFG_DATA_BITS+TICK_COUNT_BITS+1)'(TURN_MAX);
      if (wide > limit) begin
         return TURN_MAX;
      end
      return TICK_COUNT_BITS'(wide);
   endfunction

endpackage

/* hw/rtl/drvm_if.sv */
// Handshake channel interfaces for the robot drive mode controller.
// Depends on drvm_pkg for field widths.
interface drvm_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [drvm_pkg::CHAR_BITS-1:0] char_code;
   logic                           right_sensor;
   logic                           left_sensor;

   modport source (output valid, action, char_code, right_sensor, left_sensor,
                   input ready);
   modport sink   (input valid, action, char_code, right_sensor, left_sensor,
                   output ready);
endinterface

interface drvm_rsp_if;
   logic       valid;
   logic       ready;
   logic       left_fwd;
   logic       left_rev;
   logic       right_fwd;
   logic       right_rev;
   logic [1:0] mode;
   logic       turning;
   logic       dropped;

   modport source (output valid, left_fwd, left_rev, right_fwd, right_rev, mode, turning,
                   dropped, input ready);
   modport sink   (input valid, left_fwd, left_rev, right_fwd, right_rev, mode, turning,
                   dropped, output ready);
endinterface

interface drvm_csr_if;
   logic                                valid;
   logic                                ready;
   logic [drvm_pkg::CSR_INDEX_BITS-1:0] index;
   logic [drvm_pkg::CFG_DATA_BITS-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* hw/rtl/drvm_step.sv */
// Next-state and result logic of the drive controller for one beat.
// Depends on drvm_pkg for the state, item and result types.
module drvm_step (
   input  drvm_pkg::item_type                     item,
   input  drvm_pkg::state_type                    cur,
   input  logic [drvm_pkg::CFG_DATA_BITS-1:0]     manual_turn_ticks,
   input  logic [drvm_pkg::CFG_DATA_BITS-1:0]     follow_turn_ticks,
   output drvm_pkg::state_type                    nxt,
   output drvm_pkg::result_type                   result
);

   logic [drvm_pkg::TICK_COUNT_BITS-1:0] manual_len;
   logic [drvm_pkg::TICK_COUNT_BITS-1:0] follow_len;
   logic [drvm_pkg::TICK_COUNT_BITS-1:0] count_dec;
   logic                                 busy;
   logic                                 dropped;

   assign manual_len = drvm_pkg::clamp_turn(manual_turn_ticks);
   assign follow_len = drvm_pkg::clamp_turn(follow_turn_ticks);
   assign count_dec  = cur.turn_remaining - drvm_pkg::TICK_COUNT_BITS'(1);
   assign busy       = (cur.turn_remaining != '0);

   // Apply one character or one tick to the current state.
   always_comb begin
      nxt     = cur;
      dropped = 1'b0;
      if (item.action == drvm_pkg::ACTION_CHAR) begin
         case (cur.mode)
            drvm_pkg::MODE_IDLE: begin
               if (item.char_code == drvm_pkg::CHAR_MANUAL) begin
                  nxt.mode = drvm_pkg::MODE_MANUAL;
               end else if (item.char_code == drvm_pkg::CHAR_LINE) begin
                  nxt.mode = drvm_pkg::MODE_WAIT;
               end
            end
            drvm_pkg::MODE_WAIT: begin
               if (item.char_code == drvm_pkg::CHAR_GO) begin
                  nxt.mode  = drvm_pkg::MODE_FOLLOW;
                  nxt.motor = drvm_pkg::PAT_FWD;
               end else begin
                  nxt.mode = drvm_pkg::MODE_IDLE;
               end
            end
            drvm_pkg::MODE_MANUAL: begin
               // A running spin swallows every character.
               if (busy) begin
                  dropped = 1'b1;
               end else if (item.char_code == drvm_pkg::CHAR_FWD) begin
                  nxt.motor = drvm_pkg::PAT_FWD;
               end else if (item.char_code == drvm_pkg::CHAR_BACK) begin
                  nxt.motor = drvm_pkg::PAT_BACK;
               end else if (item.char_code == drvm_pkg::CHAR_STOP) begin
                  nxt.motor = drvm_pkg::PAT_OFF;
               end else if (item.char_code == drvm_pkg::CHAR_RIGHT ||
                            item.char_code == drvm_pkg::CHAR_LEFT) begin
                  nxt.turn_then_forward = 1'b0;
                  nxt.turn_remaining    = manual_len;
                  if (manual_len == '0) begin
                     nxt.motor = drvm_pkg::PAT_OFF;
                  end else if (item.char_code == drvm_pkg::CHAR_RIGHT) begin
                     nxt.motor = drvm_pkg::PAT_RIGHT;
                  end else begin
                     nxt.motor = drvm_pkg::PAT_LEFT;
                  end
               end else if (item.char_code == drvm_pkg::CHAR_QUIT) begin
                  nxt.motor = drvm_pkg::PAT_OFF;
                  nxt.mode  = drvm_pkg::MODE_IDLE;
               end
            end
            default: begin
               // Line following: only quit matters, and it waits for a turn.
               if (item.char_code == drvm_pkg::CHAR_QUIT) begin
                  if (busy) begin
                     nxt.quit_pending = 1'b1;
                  end else begin
                     nxt.motor = drvm_pkg::PAT_OFF;
                     nxt.mode  = drvm_pkg::MODE_IDLE;
                  end
               end
            end
         endcase
      end else begin
         if (busy) begin
            // Count the running turn down; its last tick settles the motors.
            nxt.turn_remaining = count_dec;
            if (count_dec == '0) begin
               nxt.motor = cur.turn_then_forward ? drvm_pkg::PAT_FWD : drvm_pkg::PAT_OFF;
               if (cur.mode == drvm_pkg::MODE_FOLLOW && cur.quit_pending) begin
                  nxt.motor        = drvm_pkg::PAT_OFF;
                  nxt.mode         = drvm_pkg::MODE_IDLE;
                  nxt.quit_pending = 1'b0;
               end
            end
         end else if (cur.mode == drvm_pkg::MODE_FOLLOW) begin
            // Sample the sensors; the right one wins when both see the line.
            if (item.right_sensor || item.left_sensor) begin
               nxt.turn_then_forward = 1'b1;
               nxt.turn_remaining    = follow_len;
               if (follow_len == '0) begin
                  nxt.motor = drvm_pkg::PAT_FWD;
               end else if (item.right_sensor) begin
                  nxt.motor = drvm_pkg::PAT_RIGHT;
               end else begin
                  nxt.motor = drvm_pkg::PAT_LEFT;
               end
            end else begin
               nxt.motor = drvm_pkg::PAT_FWD;
            end
         end
      end
   end

   // The result shows the state after the beat.
   always_comb begin
      result.left_fwd  = nxt.motor[3];
      result.left_rev  = nxt.motor[2];
      result.right_fwd = nxt.motor[1];
      result.right_rev = nxt.motor[0];
      result.mode      = nxt.mode;
      result.turning   = (nxt.turn_remaining != '0);
      result.dropped   = dropped;
   end

endmodule

/* hw/rtl/robot_drive_mode_controller_core.sv */
// Top level of the robot drive mode controller: input register, state and result register.
// Depends on drvm_pkg, the channel interfaces in drvm_if and the drvm_step logic.
// Path: an accepted input beat is held in the input register and its result in the result
// register; a stall on the result side keeps the beat waiting in the input register.
// Throughput: one beat per cycle unless the result side stalls; the state updates per item.
// Reset clears the state, loads turn lengths 149 (spin) and 49 (correction), empties channels.
module robot_drive_mode_controller_core (
   input  logic            clock,
   input  logic            reset,
   drvm_req_if.sink        req_bus,
   drvm_rsp_if.source      rsp_bus,
   drvm_csr_if.sink        csr_bus
);

   drvm_pkg::item_type                   item_ff;
   logic                                 item_valid_ff;
   drvm_pkg::state_type                  state_ff;
   drvm_pkg::state_type                  state_in;
   drvm_pkg::result_type                 result_ff;
   drvm_pkg::result_type                 result_in;
   logic                                 result_valid_ff;
   logic [drvm_pkg::CFG_DATA_BITS-1:0]   manual_turn_ff;
   logic [drvm_pkg::CFG_DATA_BITS-1:0]   follow_turn_ff;
   logic                                 advance;
   logic                                 req_beat;

   // An item moves on when the result register is free or being emptied.
   assign advance       = item_valid_ff && (!result_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !item_valid_ff || advance;
   assign req_beat      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= req_beat || (item_valid_ff && !advance);
      end
      if (req_beat) begin
         item_ff.action       <= req_bus.action;
         item_ff.char_code    <= req_bus.char_code;
         item_ff.right_sensor <= req_bus.right_sensor;
         item_ff.left_sensor  <= req_bus.left_sensor;
      end
   end

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_turn_ff <= drvm_pkg::MANUAL_TURN_RESET;
         follow_turn_ff <= drvm_pkg::FOLLOW_TURN_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            drvm_pkg::CSR_MANUAL_TURN: manual_turn_ff <= csr_bus.data;
            drvm_pkg::CSR_FOLLOW_TURN: follow_turn_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   drvm_step u_step (
      .item              (item_ff),
      .cur               (state_ff),
      .manual_turn_ticks (manual_turn_ff),
      .follow_turn_ticks (follow_turn_ff),
      .nxt               (state_in),
      .result            (result_in)
   );

   // Controller state advances once per item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode              <= drvm_pkg::MODE_IDLE;
         state_ff.motor             <= drvm_pkg::PAT_OFF;
         state_ff.turn_remaining    <= '0;
         state_ff.turn_then_forward <= 1'b0;
         state_ff.quit_pending      <= 1'b0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else begin
         result_valid_ff <= advance || (result_valid_ff && !rsp_bus.ready);
      end
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_bus.valid     = result_valid_ff;
   assign rsp_bus.left_fwd  = result_ff.left_fwd;
   assign rsp_bus.left_rev  = result_ff.left_rev;
   assign rsp_bus.right_fwd = result_ff.right_fwd;
   assign rsp_bus.right_rev = result_ff.right_rev;
   assign rsp_bus.mode      = result_ff.mode;
   assign rsp_bus.turning   = result_ff.turning;
   assign rsp_bus.dropped   = result_ff.dropped;

   // A running turn only exists in manual or following mode.
   a_turn_mode: assert property (@(posedge clock) disable iff (reset)
      (state_ff.turn_remaining != '0) |->
         (state_ff.mode == drvm_pkg::MODE_MANUAL || state_ff.mode == drvm_pkg::MODE_FOLLOW))
      else $error("turn counter running outside manual or following mode");

   // A pending quit is only held while following.
   a_quit_follow: assert property (@(posedge clock) disable iff (reset)
      state_ff.quit_pending |-> (state_ff.mode == drvm_pkg::MODE_FOLLOW))
      else $error("quit pending outside following mode");

   // A dropped character can only be reported while a manual spin runs on.
   a_drop_spin: assert property (@(posedge clock) disable iff (reset)
      (result_valid_ff && result_ff.dropped) |->
         (result_ff.turning && result_ff.mode == drvm_pkg::MODE_MANUAL))
      else $error("dropped flag without a running manual spin");

   // A held item is not lost while the result side stalls.
   a_item_held: assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && !advance) |=> (item_valid_ff && $stable(item_ff)))
      else $error("stalled input item was lost or changed");

endmodule
